[sv/pixel_gamma_encode_bgr8_core_macros.svh]
// assertion macros for the gamma encoder
`ifndef PIXEL_GAMMA_ENCODE_BGR8_CORE_MACROS_SVH
`define PIXEL_GAMMA_ENCODE_BGR8_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define PGE_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gamma encoder assertion failed");

// next-cycle implication, checked out of reset
`define PGE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gamma encoder assertion failed");

`endif

[sv/pgenc_pkg.sv]
// shared types, constants and threshold table for the gamma encoder
`default_nettype none
package pgenc_pkg;

	localparam int LW      = 22;   // log2 result, signed Q.16
	localparam int PW      = 39;   // log2 times inverse gamma, signed Q.28
	localparam int GW      = 16;   // inverse gamma width
	localparam int STEPS   = 16;   // fraction bits of the log
	localparam int LOG_LAT = STEPS + 1;
	localparam int Q_LAT   = 10;
	localparam logic [GW-1:0] INV_GAMMA_RST = 16'd1862;

	typedef struct packed {
		logic signed [31:0] red_in;
		logic signed [31:0] green_in;
		logic signed [31:0] blue_in;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] blue_byte;
		logic [7:0] green_byte;
		logic [7:0] red_byte;
	} pix_out_t;

	typedef logic signed [PW-1:0] thr_tab_t [256];

	// bit-exact log2 of a Q16.16 value, evaluated at elaboration only
	function automatic longint log2c(input longint unsigned xin);
		longint unsigned x;
		longint unsigned m;
		longint fr;
		int p;
		x = xin & 64'h7FFF_FFFF;
		fr = 0;
		p = 30;
		if (x == 0)
			return -16 * 65536;
		while (p > 0 && x[p] == 1'b0)
			p--;
		m = x << (30 - p);
		for (int i = 0; i < STEPS; i++) begin
			m = (m * m) >> 30;
			fr = fr << 1;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				fr = fr | 1;
			end
		end
		return (longint'(p) - 16) * 65536 + fr;
	endfunction

	// threshold for byte n: (log2(n) - log2(255)) * 4096
	function automatic thr_tab_t build_thr();
		thr_tab_t t;
		longint top;
		top = log2c(64'd255 << 16);
		t[0] = '0;
		for (int n = 1; n < 256; n++)
			t[n] = PW'((log2c(longint'(n) << 16) - top) * 4096);
		return t;
	endfunction

	localparam thr_tab_t THR = build_thr();

endpackage
`default_nettype wire

[sv/pgenc_log2.sv]
// one channel lane: normalize, then one squaring stage per fraction bit
`default_nettype none
module pgenc_log2 (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            vld,
	input  wire logic signed [31:0]              value,
	output logic                                 log_vld,
	output logic                                 log_pos,
	output logic signed [pgenc_pkg::LW-1:0]      log_val
);
	localparam int N = pgenc_pkg::STEPS;

	logic        vld_s  [0:N];
	logic        pos_s  [0:N];
	logic [4:0]  exp_s  [0:N];
	logic [30:0] mant_s [0:N];
	logic [15:0] frac_s [0:N];

	logic [4:0]  lead;
	logic [30:0] norm;

	// leading one position
	always_comb begin
		lead = '0;
		for (int i = 0; i < 31; i++)
			if (value[i])
				lead = 5'(i);
		norm = value[30:0] << (5'd30 - lead);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= vld;
		end
	end

	always_ff @(posedge clk) begin
		pos_s[0]  <= !value[31] && (value != '0);
		exp_s[0]  <= lead;
		mant_s[0] <= norm;
		frac_s[0] <= '0;
	end

	for (genvar k = 0; k < N; k++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] top;
		always_comb begin
			sq  = 62'(mant_s[k]) * 62'(mant_s[k]);
			top = sq[61:30];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			pos_s[k+1]  <= pos_s[k];
			exp_s[k+1]  <= exp_s[k];
			// square reached 2.0: emit a one and halve
			mant_s[k+1] <= top[31] ? top[31:1] : top[30:0];
			frac_s[k+1] <= {frac_s[k][14:0], top[31]};
		end
	end

	assign log_vld = vld_s[N];
	assign log_pos = pos_s[N];
	assign log_val = {6'({1'b0, exp_s[N]}) - 6'd16, frac_s[N]};

endmodule
`default_nettype wire

[sv/pgenc_quant.sv]
// scale log by inverse gamma, then binary search the byte thresholds
`default_nettype none
module pgenc_quant (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            vld,
	input  wire logic                            pos,
	input  wire logic signed [pgenc_pkg::LW-1:0] log_val,
	input  wire logic [pgenc_pkg::GW-1:0]        inv_gamma,
	output logic                                 byte_vld,
	output logic [7:0]                           byte_val
);
	localparam int PW = pgenc_pkg::PW;

	logic                 vld_s  [0:8];
	logic                 pos_s  [0:8];
	logic signed [PW-1:0] prod_s [0:8];
	logic [7:0]           res_s  [0:8];
	logic                 out_vld_q;
	logic [7:0]           out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= vld;
		end
	end

	always_ff @(posedge clk) begin
		pos_s[0]  <= pos;
		prod_s[0] <= PW'(log_val * $signed({1'b0, inv_gamma}));
		res_s[0]  <= '0;
	end

	for (genvar k = 0; k < 8; k++) begin : g_srch
		logic [7:0] cand;
		assign cand = res_s[k] | 8'(1 << (7 - k));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			pos_s[k+1]  <= pos_s[k];
			prod_s[k+1] <= prod_s[k];
			res_s[k+1]  <= (pgenc_pkg::THR[cand] <= prod_s[k]) ? cand : res_s[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= vld_s[8];
		end
	end

	always_ff @(posedge clk) begin
		out_q <= pos_s[8] ? res_s[8] : 8'd0;
	end

	assign byte_vld = out_vld_q;
	assign byte_val = out_q;

endmodule
`default_nettype wire

[sv/pixel_gamma_encode_bgr8_core.sv]
// gamma encoder top level: linear Q16.16 rgb in, bgr bytes out
//
// channel   signals                          direction
// pixel in  start, busy, pix_in              in
// byte out  done, pix_out                    out
// config    cfg_valid, cfg_ready, cfg_data   in
//
// one item per cycle; done is start carried through the registered pipeline,
// which holds the 16 squaring stages of the log lanes and 8 search stages
// busy and cfg_ready stay constant: the pipeline never stalls
// reset clears valid bits and loads inverse gamma 1862 (about 1/2.2)
`default_nettype none
`include "pixel_gamma_encode_bgr8_core_macros.svh"
module pixel_gamma_encode_bgr8_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire pgenc_pkg::pix_in_t         pix_in,
	output logic                            done,
	output pgenc_pkg::pix_out_t             pix_out,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [pgenc_pkg::GW-1:0]   cfg_data
);
	localparam int LAT = pgenc_pkg::LOG_LAT + pgenc_pkg::Q_LAT;

	logic [pgenc_pkg::GW-1:0] inv_gamma_q;
	logic                     acc;
	logic [2:0]               lvld;
	logic [2:0]               lpos;
	logic [2:0]               bvld;
	logic signed [pgenc_pkg::LW-1:0] lval [0:2];
	logic [7:0]               bval [0:2];
	logic signed [31:0]       chan [0:2];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign acc       = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_gamma_q <= pgenc_pkg::INV_GAMMA_RST;
		end else if (cfg_valid && cfg_ready) begin
			inv_gamma_q <= cfg_data;
		end
	end

	// lane 0 blue, 1 green, 2 red
	assign chan[0] = pix_in.blue_in;
	assign chan[1] = pix_in.green_in;
	assign chan[2] = pix_in.red_in;

	for (genvar c = 0; c < 3; c++) begin : g_lane
		pgenc_log2 u_log (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld     (acc),
			.value   (chan[c]),
			.log_vld (lvld[c]),
			.log_pos (lpos[c]),
			.log_val (lval[c])
		);
		pgenc_quant u_quant (
			.clk       (clk),
			.arst_n    (arst_n),
			.vld       (lvld[c]),
			.pos       (lpos[c]),
			.log_val   (lval[c]),
			.inv_gamma (inv_gamma_q),
			.byte_vld  (bvld[c]),
			.byte_val  (bval[c])
		);
	end

	assign done               = bvld[0];
	assign pix_out.blue_byte  = bval[0];
	assign pix_out.green_byte = bval[1];
	assign pix_out.red_byte   = bval[2];

	`PGE_ASSERT_IMPL(a_done_from_start, done, $past(acc, LAT))
	`PGE_ASSERT_IMPL(a_lanes_aligned, done, bvld[1] && bvld[2])
	`PGE_ASSERT_IMPL(a_red_nonpos, done && ($past(pix_in.red_in, LAT) <= 0), pix_out.red_byte == '0)
	`PGE_ASSERT_NEXT(a_cfg_taken, cfg_valid, inv_gamma_q == $past(cfg_data))

endmodule
`default_nettype wire
